[hw/rtl/dmxr_pkg.sv]
package dmxr_pkg;

  // Default number of DMX channels; slot 0 carries the start code.
  localparam int unsigned CHANNELS_DEF = 512;

  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CHAN_W    = 10;
  localparam int unsigned FRAMES_W  = 32;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd500;
  localparam logic [TICKS_W-1:0] TICKS_MAX     = 16'hFFFF;

  // Register index, taken from the word address of the APB port.
  localparam logic [0:0] REG_HEALTH_TIMEOUT = 1'b0;

  // Line event codes; codes above FUNC_TICK change nothing.
  localparam logic [FUNC_W-1:0] FUNC_BYTE  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_BREAK = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ERROR = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_BREAK = 2'd1,
    MODE_DATA  = 2'd2
  } mode_e;

  // Status of one item, carried from the state update to the output stage.
  typedef struct packed {
    logic                rd_hit;
    logic                healthy;
    logic [FRAMES_W-1:0] frame_count;
    mode_e               rx_mode;
  } meta_t;

endpackage

[hw/rtl/dmxr_if.sv]
interface dmxr_in_if;
  import dmxr_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [BYTE_W-1:0]   rx_byte;
  logic [CHAN_W-1:0]   channel;

  modport source (output valid, func, rx_byte, channel, input ready);
  modport sink   (input valid, func, rx_byte, channel, output ready);
endinterface

interface dmxr_out_if;
  import dmxr_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   read_data;
  logic                healthy;
  logic [FRAMES_W-1:0] frame_count;
  logic [1:0]          rx_mode;

  modport source (output valid, read_data, healthy, frame_count, rx_mode, input ready);
  modport sink   (input valid, read_data, healthy, frame_count, rx_mode, output ready);
endinterface

[hw/rtl/dmx512_frame_receiver_unit.sv]
// Channel   Dir  Handshake        Payload
// in_i      in   valid/ready      func, rx_byte, channel
// out_o     out  valid/ready      read_data, healthy, frame_count, rx_mode
// APB       in   psel/penable     health_timeout at byte address 0
//
// One item per cycle sustained while out_o is not stalled; after its item is accepted,
// a result passes through the read stage (slot store read), then the output register.
// State is updated in the cycle of acceptance, so items follow back to back.
// Reset clears all control state; the slot store is not swept: a written-prefix
// count makes never-written slots read as zero, so no clearing pass is needed.
// A stalled output fills the output register, then the read stage, then input
// ready drops.
module dmx512_frame_receiver_unit #(
  parameter int unsigned CHANNELS = dmxr_pkg::CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dmxr_in_if.sink                       in_i,
  dmxr_out_if.source                    out_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [dmxr_pkg::APB_AW-1:0]   paddr_i,
  input  logic [dmxr_pkg::APB_DW-1:0]   pwdata_i,
  output logic [dmxr_pkg::APB_DW-1:0]   prdata_o,
  output logic                          pready_o
);
  import dmxr_pkg::*;

  localparam int unsigned SLOTS = CHANNELS + 1;
  localparam int unsigned AW    = $clog2(SLOTS);

  logic [TICKS_W-1:0] timeout_q, timeout_d;
  logic [0:0]         reg_idx;
  logic               reg_wr;
  logic               acc;
  logic               in_ready;
  meta_t              meta;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [BYTE_W-1:0]  wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [BYTE_W-1:0]  rdata;

  // Configuration port: decode on the word address, ignore byte offset.
  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[2];
  assign reg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_comb begin
    timeout_d = timeout_q;
    if (reg_wr && (reg_idx == REG_HEALTH_TIMEOUT)) begin
      timeout_d = pwdata_i[TICKS_W-1:0];
    end
    prdata_o = (reg_idx == REG_HEALTH_TIMEOUT) ? APB_DW'(timeout_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  // Take an item whenever the read stage is free or moving on.
  assign in_i.ready = in_ready;
  assign acc        = in_i.valid && in_ready;

  dmxr_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .func_i    (in_i.func),
    .rx_byte_i (in_i.rx_byte),
    .channel_i (in_i.channel),
    .timeout_i (timeout_q),
    .meta_o    (meta),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .re_o      (re),
    .raddr_o   (raddr)
  );

  // Slot store: start code in slot 0, channels in 1..CHANNELS.
  dmxr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  dmxr_ostage u_ostage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (acc),
    .meta_i     (meta),
    .rdata_i    (rdata),
    .in_ready_o (in_ready),
    .out_o      (out_o)
  );

endmodule

[hw/rtl/dmxr_ram.sv]
module dmxr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 513
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/dmxr_ctrl.sv]
module dmxr_ctrl #(
  parameter int unsigned CHANNELS = dmxr_pkg::CHANNELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               acc_i,
  input  logic [dmxr_pkg::FUNC_W-1:0]        func_i,
  input  logic [dmxr_pkg::BYTE_W-1:0]        rx_byte_i,
  input  logic [dmxr_pkg::CHAN_W-1:0]        channel_i,
  input  logic [dmxr_pkg::TICKS_W-1:0]       timeout_i,
  output dmxr_pkg::meta_t                    meta_o,
  output logic                               we_o,
  output logic [$clog2(CHANNELS+1)-1:0]      waddr_o,
  output logic [dmxr_pkg::BYTE_W-1:0]        wdata_o,
  output logic                               re_o,
  output logic [$clog2(CHANNELS+1)-1:0]      raddr_o
);
  import dmxr_pkg::*;

  localparam int unsigned SLOTS = CHANNELS + 1;
  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned SW    = $clog2(SLOTS + 1);

  mode_e                mode_q, mode_d;
  logic [SW-1:0]        slot_q, slot_d;
  logic [SW-1:0]        hi_q, hi_d;     // written prefix of the store
  logic [FRAMES_W-1:0]  frames_q, frames_d;
  logic [TICKS_W-1:0]   ticks_q, ticks_d;

  logic                 is_byte;
  logic                 start;
  logic [SW-1:0]        slot_base;
  logic [SW-1:0]        slot_inc;
  logic [CHAN_W-1:0]    ch_cl;

  assign is_byte = acc_i && (func_i == FUNC_BYTE);
  assign start   = is_byte && (mode_q == MODE_BREAK) && (rx_byte_i == '0);

  // Next mode
  always_comb begin
    mode_d = mode_q;
    if (acc_i) begin
      unique case (func_i)
        FUNC_BYTE: begin
          if (mode_q == MODE_BREAK) begin
            mode_d = (rx_byte_i == '0) ? MODE_DATA : MODE_IDLE;
          end
        end
        FUNC_BREAK: mode_d = MODE_BREAK;
        FUNC_ERROR: mode_d = MODE_IDLE;
        default:    mode_d = mode_q;
      endcase
    end
  end

  // Slot, counters and store access
  always_comb begin
    slot_base = start ? '0 : slot_q;
    slot_inc  = SW'(slot_base + 1'b1);
    we_o      = is_byte && (mode_d == MODE_DATA) && (slot_base < SW'(SLOTS));
    slot_d    = we_o ? slot_inc : slot_base;
    hi_d      = (we_o && (slot_inc > hi_q)) ? slot_inc : hi_q;
    frames_d  = start ? FRAMES_W'(frames_q + 1'b1) : frames_q;
    ticks_d   = ticks_q;
    if (start) begin
      ticks_d = '0;
    end else if (acc_i && (func_i == FUNC_TICK) && (ticks_q != TICKS_MAX)) begin
      ticks_d = TICKS_W'(ticks_q + 1'b1);
    end
    waddr_o = slot_base[AW-1:0];
    wdata_o = rx_byte_i;

    // Clamp the channel into 1..CHANNELS
    if (channel_i == '0) begin
      ch_cl = CHAN_W'(1);
    end else if (channel_i > CHAN_W'(CHANNELS)) begin
      ch_cl = CHAN_W'(CHANNELS);
    end else begin
      ch_cl = channel_i;
    end
    re_o    = acc_i && (func_i == FUNC_READ);
    raddr_o = ch_cl[AW-1:0];
  end

  // Result status
  always_comb begin
    meta_o.rd_hit      = (func_i == FUNC_READ) && (ch_cl < CHAN_W'(hi_q));
    meta_o.healthy     = ticks_d < timeout_i;
    meta_o.frame_count = frames_d;
    meta_o.rx_mode     = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      slot_q   <= '0;
      hi_q     <= '0;
      frames_q <= '0;
      ticks_q  <= '0;
    end else begin
      mode_q   <= mode_d;
      slot_q   <= slot_d;
      hi_q     <= hi_d;
      frames_q <= frames_d;
      ticks_q  <= ticks_d;
    end
  end

  a_slot_within_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= hi_q) else $error("slot address beyond written prefix");

  a_prefix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_q <= SW'(SLOTS)) else $error("written prefix beyond store");

  a_write_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |=> mode_q == MODE_DATA) else $error("store written outside a frame");

  a_tick_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && (func_i == FUNC_TICK) && (ticks_q != TICKS_MAX)
    |=> ticks_q == TICKS_W'($past(ticks_q) + 1'b1)) else $error("tick not counted");

endmodule

[hw/rtl/dmxr_ostage.sv]
module dmxr_ostage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  dmxr_pkg::meta_t              meta_i,
  input  logic [dmxr_pkg::BYTE_W-1:0]  rdata_i,
  output logic                         in_ready_o,
  dmxr_out_if.source                   out_o
);
  import dmxr_pkg::*;

  logic                s1_v_q, s1_v_d;
  meta_t               s1_meta_q;
  logic                s2_v_q, s2_v_d;
  logic [BYTE_W-1:0]   rd_q;
  logic                hl_q;
  logic [FRAMES_W-1:0] fc_q;
  mode_e               md_q;
  logic                s2_free;
  logic                s1_go;

  // Stage 1 waits on the store read; stage 2 is the output register.
  assign s2_free    = !s2_v_q || out_o.ready;
  assign s1_go      = s1_v_q && s2_free;
  assign in_ready_o = !s1_v_q || s2_free;

  always_comb begin
    s1_v_d = s1_v_q;
    if (load_i) begin
      s1_v_d = 1'b1;
    end else if (s1_go) begin
      s1_v_d = 1'b0;
    end
    s2_v_d = s2_v_q;
    if (s1_go) begin
      s2_v_d = 1'b1;
    end else if (out_o.ready) begin
      s2_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_meta_q <= meta_i;
    end
    if (s1_go) begin
      rd_q <= s1_meta_q.rd_hit ? rdata_i : '0;
      hl_q <= s1_meta_q.healthy;
      fc_q <= s1_meta_q.frame_count;
      md_q <= s1_meta_q.rx_mode;
    end
  end

  assign out_o.valid       = s2_v_q;
  assign out_o.read_data   = rd_q;
  assign out_o.healthy     = hl_q;
  assign out_o.frame_count = fc_q;
  assign out_o.rx_mode     = md_q;

endmodule

[tb/sv/dmxr_frame_checker.sv]
`timescale 1ns / 1ps

module dmxr_frame_checker #(
  parameter int unsigned CHANNELS = dmxr_pkg::CHANNELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dmxr_in_if                          in_mon,
  dmxr_out_if                         out_mon,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [dmxr_pkg::APB_AW-1:0] paddr_i,
  input  logic [dmxr_pkg::APB_DW-1:0] pwdata_i,
  input  logic                        pready_i,
  output int                          fail_count_o,
  output int                          pending_count_o,
  output int                          checked_count_o,
  output int                          frames_opened_o
);
  import dmxr_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]   level;
    logic                healthy;
    logic [FRAMES_W-1:0] frames;
    mode_e               mode;
  } line_status_t;

  // Shadow of the receiver
  mode_e               line_mode;
  logic [CHAN_W-1:0]   next_slot;
  logic [BYTE_W-1:0]   levels [0:CHANNELS];
  logic [FRAMES_W-1:0] frame_total;
  logic [TICKS_W-1:0]  tick_total;
  logic [TICKS_W-1:0]  timeout_reg;

  line_status_t awaited_status [$];
  line_status_t want;
  line_status_t seen;

  // Advance the shadow by one line event and return the status it reports.
  task automatic apply_event(input logic [FUNC_W-1:0] code, input logic [BYTE_W-1:0] b,
                             input logic [CHAN_W-1:0] ch, output line_status_t st);
    logic [CHAN_W-1:0] idx;
    st.level = '0;
    case (code)
      FUNC_BYTE: begin
        if (line_mode == MODE_BREAK) begin
          if (b == '0) begin
            line_mode   = MODE_DATA;
            next_slot   = '0;
            tick_total  = '0;
            frame_total = frame_total + 1'b1;
            frames_opened_o++;
          end else begin
            line_mode = MODE_IDLE;
          end
        end
        if (line_mode == MODE_DATA && next_slot <= CHANNELS) begin
          levels[next_slot] = b;
          next_slot         = next_slot + 1'b1;
        end
      end
      FUNC_BREAK: line_mode = MODE_BREAK;
      FUNC_ERROR: line_mode = MODE_IDLE;
      FUNC_READ: begin
        idx = ch;
        if (idx < 1) idx = CHAN_W'(1);
        else if (idx > CHANNELS) idx = CHAN_W'(CHANNELS);
        st.level = levels[idx];
      end
      FUNC_TICK: begin
        if (tick_total != TICKS_MAX) tick_total = tick_total + 1'b1;
      end
      default: ;
    endcase
    st.healthy = (tick_total < timeout_reg);
    st.frames  = frame_total;
    st.mode    = line_mode;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode   = MODE_IDLE;
      next_slot   = '0;
      frame_total = '0;
      tick_total  = '0;
      timeout_reg = TIMEOUT_RESET;
      for (int i = 0; i <= CHANNELS; i++) levels[i] = '0;
      awaited_status.delete();
      fail_count_o    = 0;
      pending_count_o = 0;
      checked_count_o = 0;
      frames_opened_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[APB_AW-1:2] == REG_HEALTH_TIMEOUT)
        timeout_reg = pwdata_i[TICKS_W-1:0];

      if (in_mon.valid && in_mon.ready) begin
        apply_event(in_mon.func, in_mon.rx_byte, in_mon.channel, want);
        awaited_status.push_back(want);
      end

      if (out_mon.valid && out_mon.ready) begin
        seen.level   = out_mon.read_data;
        seen.healthy = out_mon.healthy;
        seen.frames  = out_mon.frame_count;
        seen.mode    = mode_e'(out_mon.rx_mode);
        checked_count_o++;
        if (awaited_status.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("[%0t] unexpected result: data %02h healthy %0b frames %0d mode %0d",
                     $realtime, seen.level, seen.healthy, seen.frames, seen.mode);
        end else begin
          want = awaited_status.pop_front();
          if (seen.level !== want.level || seen.healthy !== want.healthy ||
              seen.frames !== want.frames || seen.mode !== want.mode) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("[%0t] mismatch: expected data %02h healthy %0b frames %0d mode %0d",
                       $realtime, want.level, want.healthy, want.frames, want.mode);
              $display("[%0t]           got data %02h healthy %0b frames %0d mode %0d",
                       $realtime, seen.level, seen.healthy, seen.frames, seen.mode);
            end
          end
        end
      end
      pending_count_o = awaited_status.size();
    end
  end

endmodule

[tb/sv/tb_dmx512_frame_receiver_unit.sv]
`timescale 1ns / 1ps

module tb_dmx512_frame_receiver_unit;
  import dmxr_pkg::*;

  localparam int unsigned CHANNELS    = CHANNELS_DEF;
  localparam int          CYCLE_LIMIT = 1_000_000;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending_count;
  int checked_count;
  int frames_opened;
  int items_sent;
  int cycles;
  int stall_left;
  bit quiet;

  dmxr_in_if  in_ch ();
  dmxr_out_if out_ch ();

  dmx512_frame_receiver_unit #(
    .CHANNELS (CHANNELS)
  ) uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  // Watch both channels and the register port; predict and compare every result
  dmxr_frame_checker #(
    .CHANNELS (CHANNELS)
  ) checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count),
    .checked_count_o (checked_count),
    .frames_opened_o (frames_opened)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Guard against a hung handshake
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding", cycles,
               pending_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Idle length: mostly none, often short, occasionally long; none at all when quiet
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Channel choice: favour the low slots that short frames actually fill,
  // keep the clamp corners and the full 10-bit range in play.
  function automatic logic [CHAN_W-1:0] pick_channel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CHAN_W'($urandom_range(0, 40));
    if (r < 70) begin
      case ($urandom_range(0, 5))
        0:       return '0;
        1:       return CHAN_W'(1);
        2:       return CHAN_W'(CHANNELS - 1);
        3:       return CHAN_W'(CHANNELS);
        4:       return CHAN_W'(CHANNELS + 1);
        default: return '1;
      endcase
    end
    return CHAN_W'($urandom());
  endfunction

  // Result side: stall the sink in runs of random length
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Present one item after an optional gap and hold it until it is taken.
  task automatic put_item(input logic [FUNC_W-1:0] code, input logic [BYTE_W-1:0] b,
                          input logic [CHAN_W-1:0] ch);
    int gap;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= code;
    in_ch.rx_byte <= b;
    in_ch.channel <= ch;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Drop valid, let every result drain, then write the timeout register over APB.
  // Each item yields exactly one result, so an empty queue means the block is idle.
  task automatic write_timeout(input logic [TICKS_W-1:0] value);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_HEALTH_TIMEOUT, 2'b00};
    pwdata  <= {(APB_DW-TICKS_W)'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Break, start code, then data bytes; sprinkle ticks and reads, and now and
  // then cut the frame short with a line error or a fresh break.
  task automatic send_frame(input int n_bytes, input logic [BYTE_W-1:0] start_code);
    int r;
    put_item(FUNC_BREAK, BYTE_W'($urandom()), CHAN_W'($urandom()));
    put_item(FUNC_BYTE, start_code, CHAN_W'($urandom()));
    for (int i = 0; i < n_bytes; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) put_item(FUNC_TICK, BYTE_W'($urandom()), CHAN_W'($urandom()));
      else if (r < 8) put_item(FUNC_READ, BYTE_W'($urandom()), pick_channel());
      else if (r == 8) begin
        put_item(($urandom_range(0, 1) != 0) ? FUNC_ERROR : FUNC_BREAK,
                 BYTE_W'($urandom()), CHAN_W'($urandom()));
        return;
      end
      put_item(FUNC_BYTE, BYTE_W'($urandom()), CHAN_W'($urandom()));
    end
  endtask

  // Mostly well-formed frames with random content, plus reads, tick bursts and noise
  task automatic random_traffic(input int n_items);
    int first;
    int r;
    int n;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(0, 99) < 3) quiet = !quiet;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        n = $urandom_range(0, 99);
        if (n < 85) n = $urandom_range(1, 24);
        else if (n < 95) n = $urandom_range(25, 200);
        else n = $urandom_range(CHANNELS - 8, CHANNELS + 8);
        send_frame(n, ($urandom_range(0, 99) < 85) ? '0 : BYTE_W'($urandom_range(1, 255)));
      end else if (r < 70) begin
        put_item(FUNC_READ, BYTE_W'($urandom()), pick_channel());
      end else if (r < 82) begin
        repeat ($urandom_range(1, 30))
          put_item(FUNC_TICK, BYTE_W'($urandom()), CHAN_W'($urandom()));
      end else begin
        case ($urandom_range(0, 3))
          0: put_item(FUNC_ERROR, BYTE_W'($urandom()), CHAN_W'($urandom()));
          1: put_item(FUNC_W'($urandom_range(FUNC_TICK + 1, (1 << FUNC_W) - 1)),
                      BYTE_W'($urandom()), CHAN_W'($urandom()));
          2: put_item(FUNC_BYTE, BYTE_W'($urandom()), CHAN_W'($urandom()));
          default: put_item(FUNC_BREAK, BYTE_W'($urandom()), CHAN_W'($urandom()));
        endcase
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    int unsigned phase_timeouts [6];

    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_BYTE;
    in_ch.rx_byte  = '0;
    in_ch.channel  = '0;
    items_sent     = 0;
    quiet          = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reads of the never-written store, clamped at both ends, with the reset timeout
    put_item(FUNC_READ, 8'hFF, '0);
    put_item(FUNC_READ, 8'h00, '1);
    put_item(FUNC_TICK, 8'h5A, 10'h2A5);
    // Spare codes: status only, read data zero
    for (int c = FUNC_TICK + 1; c < (1 << FUNC_W); c++)
      put_item(FUNC_W'(c), 8'hA5, 10'h15A);
    // A byte while idle goes nowhere
    put_item(FUNC_BYTE, 8'hFF, '0);
    put_item(FUNC_ERROR, '0, '0);
    // Good frame with extreme byte values
    put_item(FUNC_BREAK, '0, '0);
    put_item(FUNC_BYTE, 8'h00, '1);
    put_item(FUNC_BYTE, 8'hFF, '0);
    put_item(FUNC_BYTE, 8'h00, '0);
    put_item(FUNC_BYTE, 8'hA5, '0);
    put_item(FUNC_BYTE, 8'h5A, '0);
    put_item(FUNC_READ, '0, CHAN_W'(1));
    put_item(FUNC_READ, '0, CHAN_W'(2));
    put_item(FUNC_READ, '0, '0);
    // Break in mid frame, then a non-zero start code: frame ignored, slots kept
    put_item(FUNC_BREAK, '0, '0);
    put_item(FUNC_BYTE, 8'h80, '0);
    put_item(FUNC_BYTE, 8'h12, '0);
    put_item(FUNC_READ, '0, CHAN_W'(1));
    // Line error during data drops back to idle
    put_item(FUNC_BREAK, '0, '0);
    put_item(FUNC_BYTE, 8'h00, '0);
    put_item(FUNC_BYTE, 8'h33, '0);
    put_item(FUNC_ERROR, '0, '0);
    put_item(FUNC_READ, '0, '1);

    // Zero timeout: never healthy
    write_timeout('0);
    put_item(FUNC_TICK, '0, '0);
    put_item(FUNC_READ, '0, CHAN_W'(1));
    // Timeout of one: healthy only straight after a frame opens
    write_timeout(TICKS_W'(1));
    send_frame(1, '0);
    put_item(FUNC_TICK, '0, '0);
    put_item(FUNC_TICK, '0, '0);

    // Fill every slot and overrun the store; read at and around the upper clamp corner
    write_timeout(TIMEOUT_RESET);
    quiet = 1'b1;
    put_item(FUNC_BREAK, '0, '0);
    put_item(FUNC_BYTE, 8'h00, '0);
    for (int i = 0; i < CHANNELS + 6; i++)
      put_item(FUNC_BYTE, BYTE_W'($urandom()), CHAN_W'($urandom()));
    quiet = 1'b0;
    put_item(FUNC_READ, '0, CHAN_W'(CHANNELS));
    put_item(FUNC_READ, '0, CHAN_W'(CHANNELS + 1));
    put_item(FUNC_READ, '0, CHAN_W'(CHANNELS - 1));

    // Largest timeout: the link stays healthy through a tick burst
    write_timeout(TICKS_MAX);
    quiet = 1'b1;
    send_frame(2, '0);
    repeat (40)
      put_item(FUNC_TICK, BYTE_W'($urandom()), CHAN_W'($urandom()));
    put_item(FUNC_READ, '0, CHAN_W'(1));
    quiet = 1'b0;
    send_frame(3, '0);

    // Random phases across a spread of timeouts, small ones to make health flip
    phase_timeouts = '{5, 25, TIMEOUT_RESET, 0, 1, 0};
    phase_timeouts[5] = $urandom_range(1, int'(TICKS_MAX));
    foreach (phase_timeouts[p]) begin
      write_timeout(TICKS_W'(phase_timeouts[p]));
      random_traffic(170);
    end

    // Hold input idle, drain, then let the pipeline settle
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items, checked %0d results, %0d frames opened with a zero start code.",
             items_sent, checked_count, frames_opened);
    $display("Timeouts 0 to 65535 written; store overrun and clamped reads hit.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, pending_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
